[rtl/core/itp_pkg.sv]
// Shared types, character codes and helper functions for the infix to prefix converter.
`default_nettype none

package itp_pkg;

  localparam int unsigned BufferDepthDefault = 64;
  localparam int unsigned StackDepthDefault  = 32;

  localparam logic [7:0] ChDiv   = 8'h2F;  // '/'
  localparam logic [7:0] ChMul   = 8'h2A;  // '*'
  localparam logic [7:0] ChAdd   = 8'h2B;  // '+'
  localparam logic [7:0] ChSub   = 8'h2D;  // '-'
  localparam logic [7:0] ChOpen  = 8'h28;  // '('
  localparam logic [7:0] ChClose = 8'h29;  // ')'

  localparam logic [1:0] RankLow = 2'd0;
  localparam logic [1:0] RankAdd = 2'd1;
  localparam logic [1:0] RankMul = 2'd2;

  typedef struct packed {
    logic [7:0] ch;
    logic       final_char;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_out;
    logic       error;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;       // capture the input transaction
    logic append_ch;   // append the held character to the output buffer
    logic push_ch;     // push the held character onto the operator stack
    logic st_read;     // read the stack top into the read register
    logic pop;         // drop the stack top
    logic append_top;  // append the read stack entry to the output buffer
    logic set_err;     // record an error
    logic buf_read;    // read the newest buffer entry and shrink the buffer
    logic set_empty;   // the result is the single empty-output transaction
    logic clear;       // end of expression: clear error and empty marks
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_operand;
    logic is_open;
    logic is_close;
    logic fin;
    logic st_empty;
    logic top_is_close;
    logic top_outranks;
    logic ob_empty;
  } sts_t;

  function automatic logic [1:0] rank_of(input logic [7:0] c);
    logic [1:0] r;
    if (c == ChMul || c == ChDiv) begin
      r = RankMul;
    end else if (c == ChAdd || c == ChSub) begin
      r = RankAdd;
    end else begin
      r = RankLow;
    end
    return r;
  endfunction

  function automatic logic is_operand(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h30) && (c <= 8'h39));
  endfunction

endpackage

`default_nettype wire

[rtl/core/itp_dp.sv]
// Datapath of the converter: operator stack, output buffer, counters and result payload.
`default_nettype none

module itp_dp #(
  parameter int unsigned BUFFER_DEPTH = itp_pkg::BufferDepthDefault,
  parameter int unsigned STACK_DEPTH  = itp_pkg::StackDepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire itp_pkg::in_t  in_data_i,
  input  wire itp_pkg::cmd_t cmd_i,
  output itp_pkg::sts_t      sts_o,
  output itp_pkg::out_t      out_data_o
);

  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned SCW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned BAW = $clog2(BUFFER_DEPTH);
  localparam int unsigned BCW = $clog2(BUFFER_DEPTH + 1);

  logic [7:0]     st_mem [STACK_DEPTH];
  logic [7:0]     ob_mem [BUFFER_DEPTH];

  logic [7:0]     ch_q;
  logic           fin_q;
  logic [7:0]     st_rd_q;
  logic [7:0]     ob_rd_q;
  logic [SCW-1:0] st_cnt_q, st_cnt_d;
  logic [BCW-1:0] ob_cnt_q, ob_cnt_d;
  logic           err_q, err_d;
  logic           empty_q, empty_d;

  logic [SCW-1:0] st_top;
  logic [BCW-1:0] ob_top;
  logic           st_full;
  logic           ob_full;
  logic           do_append;
  logic [7:0]     append_val;
  logic           do_push;

  assign st_top  = st_cnt_q - SCW'(1);
  assign ob_top  = ob_cnt_q - BCW'(1);
  assign st_full = (st_cnt_q >= SCW'(STACK_DEPTH));
  assign ob_full = (ob_cnt_q >= BCW'(BUFFER_DEPTH));

  assign do_append  = cmd_i.append_ch || cmd_i.append_top;
  assign append_val = cmd_i.append_top ? st_rd_q : ch_q;
  assign do_push    = cmd_i.push_ch && !st_full;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      ch_q  <= in_data_i.ch;
      fin_q <= in_data_i.final_char;
    end
    if (do_push) begin
      st_mem[st_cnt_q[SAW-1:0]] <= ch_q;
    end
    if (cmd_i.st_read) begin
      st_rd_q <= st_mem[st_top[SAW-1:0]];
    end
    if (do_append && !ob_full) begin
      ob_mem[ob_cnt_q[BAW-1:0]] <= append_val;
    end
    if (cmd_i.buf_read) begin
      ob_rd_q <= ob_mem[ob_top[BAW-1:0]];
    end
  end

  always_comb begin
    st_cnt_d = st_cnt_q;
    ob_cnt_d = ob_cnt_q;
    err_d    = err_q;
    empty_d  = empty_q;
    if (do_push) begin
      st_cnt_d = st_cnt_q + SCW'(1);
    end else if (cmd_i.pop) begin
      st_cnt_d = st_top;
    end
    if (do_append && !ob_full) begin
      ob_cnt_d = ob_cnt_q + BCW'(1);
    end else if (cmd_i.buf_read) begin
      ob_cnt_d = ob_top;
    end
    // Overflow on either store drops the character and marks the expression.
    if (cmd_i.set_err || (cmd_i.push_ch && st_full) || (do_append && ob_full)) begin
      err_d = 1'b1;
    end
    if (cmd_i.set_empty) begin
      empty_d = 1'b1;
    end
    if (cmd_i.clear) begin
      err_d   = 1'b0;
      empty_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_cnt_q <= '0;
      ob_cnt_q <= '0;
      err_q    <= 1'b0;
      empty_q  <= 1'b0;
    end else begin
      st_cnt_q <= st_cnt_d;
      ob_cnt_q <= ob_cnt_d;
      err_q    <= err_d;
      empty_q  <= empty_d;
    end
  end

  assign sts_o.is_operand   = itp_pkg::is_operand(ch_q);
  assign sts_o.is_open      = (ch_q == itp_pkg::ChOpen);
  assign sts_o.is_close     = (ch_q == itp_pkg::ChClose);
  assign sts_o.fin          = fin_q;
  assign sts_o.st_empty     = (st_cnt_q == '0);
  assign sts_o.top_is_close = (st_rd_q == itp_pkg::ChClose);
  assign sts_o.top_outranks = (itp_pkg::rank_of(ch_q) < itp_pkg::rank_of(st_rd_q));
  assign sts_o.ob_empty     = (ob_cnt_q == '0);

  assign out_data_o.out_char = empty_q ? 8'h00 : ob_rd_q;
  assign out_data_o.last_out = (ob_cnt_q == '0);
  assign out_data_o.error    = err_q;

endmodule

`default_nettype wire

[rtl/core/itp_ctrl.sv]
// Controller state machine that sequences stack walks, the final flush and the result stream.
`default_nettype none

module itp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire itp_pkg::sts_t sts_i,
  output itp_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_EVAL,
    S_FLUSH_RD,
    S_FLUSH_EV,
    S_EMIT_RD,
    S_EMIT_WAIT
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;
  logic   valid_q, valid_d;
  state_e after_char;

  // Once a character is handled, either wait for the next one or close the expression.
  assign after_char = sts_i.fin ? S_FLUSH_RD : S_IDLE;

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !stall_q) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_operand) begin
          cmd_o.append_ch = 1'b1;
          state_d         = after_char;
        end else if (sts_i.is_close) begin
          cmd_o.push_ch = 1'b1;
          state_d       = after_char;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (sts_i.st_empty) begin
          // An opening bracket that finds no closing one is an error.
          if (sts_i.is_open) begin
            cmd_o.set_err = 1'b1;
          end else begin
            cmd_o.push_ch = 1'b1;
          end
          state_d = after_char;
        end else begin
          cmd_o.st_read = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.is_open) begin
          cmd_o.pop = 1'b1;
          if (sts_i.top_is_close) begin
            state_d = after_char;
          end else begin
            cmd_o.append_top = 1'b1;
            state_d          = S_READ;
          end
        end else if (sts_i.top_outranks) begin
          cmd_o.pop        = 1'b1;
          cmd_o.append_top = 1'b1;
          state_d          = S_READ;
        end else begin
          cmd_o.push_ch = 1'b1;
          state_d       = after_char;
        end
      end
      S_FLUSH_RD: begin
        if (!sts_i.st_empty) begin
          cmd_o.st_read = 1'b1;
          state_d       = S_FLUSH_EV;
        end else if (sts_i.ob_empty) begin
          cmd_o.set_empty = 1'b1;
          valid_d         = 1'b1;
          state_d         = S_EMIT_WAIT;
        end else begin
          state_d = S_EMIT_RD;
        end
      end
      S_FLUSH_EV: begin
        cmd_o.pop        = 1'b1;
        cmd_o.append_top = 1'b1;
        state_d          = S_FLUSH_RD;
      end
      S_EMIT_RD: begin
        cmd_o.buf_read = 1'b1;
        valid_d        = 1'b1;
        state_d        = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (!out_stall_i) begin
          valid_d = 1'b0;
          if (sts_i.ob_empty) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end else begin
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // The input is open only while the controller waits for a character.
    stall_d = (state_d != S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stall_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = stall_q;
  assign out_valid_o = valid_q;

endmodule

`default_nettype wire

[rtl/core/infix_to_prefix_converter.sv]
// Top level of the infix to prefix converter.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i / in_stall_o  itp_pkg::in_t  (ch, final_char)
//   out      output     out_valid_o / out_stall_i itp_pkg::out_t (out_char, last_out, error)
//
// An operand or ')' is decoded and then stored directly; any other character walks the stack,
// reading and then evaluating each entry inspected, with one more read if the walk reaches an
// empty stack (the stack read port is registered). The final character then flushes the stack,
// reading and appending each entry; each result is then read and offered, held by out_stall_i.
// No input transaction is taken while an expression's results are being delivered.
// After reset the block is ready at once; the stores need no clearing pass.
`default_nettype none

module infix_to_prefix_converter #(
  parameter int unsigned BUFFER_DEPTH = itp_pkg::BufferDepthDefault,
  parameter int unsigned STACK_DEPTH  = itp_pkg::StackDepthDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire itp_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output itp_pkg::out_t     out_data_o
);

  itp_pkg::cmd_t cmd;
  itp_pkg::sts_t sts;

  itp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  itp_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

[rtl/core/itp_checker.sv]
// Port-level checker for the infix to prefix converter, bound to the top level.
`default_nettype none

module itp_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire itp_pkg::out_t out_data_o
);

  logic in_txn;
  logic out_txn;

  assign in_txn  = in_valid_i && !in_stall_o;
  assign out_txn = out_valid_o && !out_stall_i;

  // A stalled result must hold its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // Results are only offered while new characters are held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result offered while input is open");

  // After a character is taken the input is closed in the next cycle and no result is offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_txn |=> (in_stall_o && !out_valid_o))
    else $error("input not closed after a transaction");

  // The last result of an expression ends the stream and reopens the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_txn && out_data_o.last_out) |=> (!out_valid_o && !in_stall_o))
    else $error("stream did not end after the last result");

endmodule

bind infix_to_prefix_converter itp_checker u_itp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
